### rtl/core/indexed_linked_list_engine_assert.svh
// Assertion macros for the indexed linked list engine.
`ifndef INDEXED_LINKED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LINKED_LIST_ENGINE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define ILL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ILL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

### rtl/core/ille_pkg.sv
// ----------------------------------------------------------------------------
// ille_pkg
// Types and codes shared by the indexed linked list engine.
// ----------------------------------------------------------------------------
package ille_pkg;
	// Number of nodes in the store; the field widths below are sized for it.
	localparam int CAPACITY = 256;

	localparam logic [2:0] OP_GET    = 3'd0;
	localparam logic [2:0] OP_SET    = 3'd1;
	localparam logic [2:0] OP_APPEND = 3'd2;
	localparam logic [2:0] OP_INSERT = 3'd3;
	localparam logic [2:0] OP_REMOVE = 3'd4;
	localparam logic [2:0] OP_SEARCH = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [8:0]         position;
		logic signed [31:0] item_value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data_out;
		logic               found;
		logic [7:0]         found_position;
		logic [8:0]         list_length;
	} rsp_t;
endpackage

### rtl/core/indexed_linked_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_linked_list_engine
// Positional list of signed words in a fixed node store with a free list.
// ----------------------------------------------------------------------------
// Usage: raise start with req for one cycle while busy is low; the request
// transaction is taken at that edge. The result appears on rsp for exactly
// one cycle with done high; the receiver cannot stall, so it must capture it.
// Each operation walks node links from the head, each link read passing
// through a walk state and a wait state on the single-port link memory;
// get, set, insert and remove walk to the position, append walks the whole
// list and search up to its length. One transaction is in flight at a time.
// After reset the sequencer chains the free list through the link memory,
// one node a cycle, until every node is linked; busy stays high until then.
// ----------------------------------------------------------------------------
`include "indexed_linked_list_engine_assert.svh"
module indexed_linked_list_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ille_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output ille_pkg::rsp_t rsp
);
	import ille_pkg::*;

	logic q_valid, q_pop, back_idle;
	req_t q_req;

	ille_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
		.q_valid(q_valid), .q_req(q_req), .q_pop(q_pop), .back_idle(back_idle));

	ille_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_req(q_req),
		.q_pop(q_pop), .idle(back_idle), .done(done), .rsp(rsp));

	// A result never arrives while the engine reports free.
	`ILL_ASSERT_IMP(a_done_busy, clk, arst_n, done, busy, "done while not busy")
	// Results are single-cycle strobes.
	`ILL_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "done held")
	// Accepted request makes the engine busy.
	`ILL_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "not busy")
endmodule

### rtl/core/ille_ram.sv
// ----------------------------------------------------------------------------
// ille_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ille_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One access per cycle: a read, with an optional write to the same address; the read returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### rtl/core/ille_front.sv
// ----------------------------------------------------------------------------
// ille_front
// Request intake and a two-entry queue toward the list sequencer.
// ----------------------------------------------------------------------------
module ille_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ille_pkg::req_t req,
	output logic          busy,
	output logic          q_valid,
	output ille_pkg::req_t q_req,
	input  logic          q_pop,
	input  logic          back_idle
);
	import ille_pkg::*;

	req_t       buf_q [2];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	logic       push;

	// Requests depend on the full outcome of the previous one, so intake
	// admits one outstanding transaction across the queue and sequencer.
	assign busy    = (cnt_q != 2'd0) || !back_idle;
	assign push    = start && !busy;
	assign q_valid = cnt_q != 2'd0;
	assign q_req   = buf_q[rd_q];

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= req;
	end
endmodule

### rtl/core/ille_back.sv
// ----------------------------------------------------------------------------
// ille_back
// List sequencer: walks links in the node store and applies each operation.
// ----------------------------------------------------------------------------
module ille_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  ille_pkg::req_t q_req,
	output logic           q_pop,
	output logic           idle,
	output logic           done,
	output ille_pkg::rsp_t rsp
);
	import ille_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int LW = AW + 1;
	localparam logic [LW-1:0] NIL = LW'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE, S_INIT, S_WALK, S_WAIT, S_FETCH, S_APPLY, S_FIN, S_DONE
	} state_t;

	state_t        state_q;
	req_t          r_q;
	logic [LW-1:0] head_q, free_q, count_q, cur_q, idx_q, steps_q, init_q;
	logic [LW-1:0] prev_q, rem_q;
	logic [1:0]    phase_q;
	rsp_t          rsp_q;
	logic          done_q;

	logic          v_we, l_we;
	logic [AW-1:0] v_addr, l_addr;
	logic [31:0]   v_wd, v_rd;
	logic [LW-1:0] l_wd, l_rd;

	ille_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val (
		.clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wd), .rdata(v_rd));
	ille_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_link (
		.clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wd), .rdata(l_rd));

	assign idle  = (state_q == S_IDLE);
	assign q_pop = idle && q_valid;
	assign done  = done_q;
	assign rsp   = rsp_q;

	// Memory port control, driven from the current state.
	always_comb begin
		v_we = 1'b0; l_we = 1'b0;
		v_addr = cur_q[AW-1:0]; l_addr = cur_q[AW-1:0];
		v_wd = r_q.item_value; l_wd = '0;
		unique case (state_q)
			S_INIT: begin
				l_we = 1'b1; l_addr = init_q[AW-1:0];
				l_wd = (init_q == NIL - 1'b1) ? NIL : init_q + 1'b1;
			end
			S_APPLY: begin
				unique case (phase_q)
					2'd0: begin
						// Append or insert: the new node takes value and link; set writes the value.
						if (r_q.req_type == OP_APPEND || r_q.req_type == OP_INSERT) begin
							v_we = 1'b1; v_addr = free_q[AW-1:0];
							l_we = 1'b1; l_addr = free_q[AW-1:0];
							l_wd = (idx_q == '0) ? head_q : l_rd;
						end else if (r_q.req_type == OP_SET && cur_q < NIL) begin
							v_we = 1'b1;
						end else if (r_q.req_type == OP_REMOVE) begin
							l_addr = rem_q[AW-1:0];
						end
					end
					2'd1: begin
						// Relink predecessor or read the removed node's link.
						if (r_q.req_type == OP_APPEND || r_q.req_type == OP_INSERT) begin
							l_we = (idx_q != '0) && (prev_q < NIL);
							l_addr = prev_q[AW-1:0]; l_wd = free_q;
						end else begin
							l_addr = rem_q[AW-1:0]; v_addr = rem_q[AW-1:0];
						end
					end
					default: begin
						// Remove: bypass and free the node.
						if (phase_q == 2'd2) begin
							l_we = (idx_q != '0) && (prev_q < NIL);
							l_addr = prev_q[AW-1:0]; l_wd = l_rd;
						end else begin
							l_we = rem_q < NIL;
							l_addr = rem_q[AW-1:0]; l_wd = free_q;
						end
					end
				endcase
			end
			default: ;
		endcase
	end

	// Sequencer state and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT; init_q <= '0; head_q <= NIL; free_q <= '0;
			count_q <= '0; done_q <= 1'b0; cur_q <= '0; idx_q <= '0;
			steps_q <= '0; phase_q <= '0; prev_q <= '0; rem_q <= '0;
			r_q <= '0; rsp_q <= '0;
		end else begin
			done_q <= (state_q == S_FIN);
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == NIL - 1'b1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid) begin
						r_q <= q_req; state_q <= S_FETCH; cur_q <= head_q;
						idx_q <= '0; phase_q <= '0;
						rsp_q <= '0;
					end
				end
				S_FETCH: begin
					// Classify and set the walk length; insert and remove at the
					// head have a zero walk since their position is zero.
					unique case (r_q.req_type)
						OP_GET, OP_SET: begin
							if ({1'b0, r_q.position} >= {1'b0, count_q}) begin
								rsp_q.status <= ST_RANGE; state_q <= S_FIN;
							end else begin
								steps_q <= LW'(r_q.position); state_q <= S_WALK;
							end
						end
						OP_APPEND, OP_INSERT: begin
							if (r_q.req_type == OP_INSERT &&
							    {1'b0, r_q.position} > {1'b0, count_q}) begin
								rsp_q.status <= ST_RANGE; state_q <= S_FIN;
							end else if (free_q >= NIL) begin
								rsp_q.status <= ST_FULL; state_q <= S_FIN;
							end else begin
								steps_q <= (r_q.req_type == OP_APPEND) ? count_q
									: LW'(r_q.position);
								idx_q <= (r_q.req_type == OP_APPEND) ? count_q
									: LW'(r_q.position);
								state_q <= S_WALK;
							end
						end
						OP_REMOVE: begin
							if ({1'b0, r_q.position} >= {1'b0, count_q}) begin
								rsp_q.status <= ST_RANGE; state_q <= S_FIN;
							end else begin
								steps_q <= LW'(r_q.position);
								idx_q <= LW'(r_q.position);
								state_q <= S_WALK;
							end
						end
						OP_SEARCH: begin
							steps_q <= count_q; state_q <= S_WALK;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_WALK: begin
					// One link read per step; search compares each value.
					if (r_q.req_type == OP_SEARCH) begin
						if (steps_q == '0 || cur_q >= NIL) state_q <= S_FIN;
						else state_q <= S_WAIT;
					end else if ((r_q.req_type == OP_GET || r_q.req_type == OP_SET)
						? (steps_q == '0 || cur_q >= NIL)
						: (steps_q <= LW'(1) || cur_q >= NIL)) begin
						prev_q <= cur_q;
						state_q <= S_WAIT; steps_q <= '0;
					end else state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (r_q.req_type == OP_SEARCH) begin
						if (v_rd == r_q.item_value) begin
							rsp_q.found <= 1'b1;
							rsp_q.found_position <= idx_q[7:0];
							state_q <= S_FIN;
						end else begin
							cur_q <= l_rd; idx_q <= idx_q + 1'b1;
							steps_q <= steps_q - 1'b1; state_q <= S_WALK;
						end
					end else if (steps_q == '0 && prev_q == cur_q) begin
						state_q <= S_APPLY;
						if (r_q.req_type == OP_GET || r_q.req_type == OP_SET)
							rsp_q.data_out <= (cur_q < NIL) ? v_rd : '0;
						if (r_q.req_type == OP_REMOVE)
							rem_q <= (idx_q == '0) ? head_q : l_rd;
					end else begin
						cur_q <= l_rd; steps_q <= steps_q - 1'b1;
						state_q <= S_WALK;
					end
				end
				S_APPLY: begin
					phase_q <= phase_q + 1'b1;
					unique case (r_q.req_type)
						OP_APPEND, OP_INSERT: begin
							// The old link of the new node, read while it was
							// written, is the next free node.
							if (phase_q == 2'd1) begin
								free_q <= l_rd;
								if (idx_q == '0) head_q <= free_q;
								count_q <= count_q + 1'b1; state_q <= S_FIN;
							end
						end
						OP_REMOVE: begin
							if (phase_q == 2'd2) begin
								rsp_q.data_out <= (rem_q < NIL) ? v_rd : '0;
								if (idx_q == '0) head_q <= (rem_q < NIL) ? l_rd : NIL;
							end else if (phase_q == 2'd3) begin
								if (rem_q < NIL) free_q <= rem_q;
								count_q <= count_q - 1'b1; state_q <= S_FIN;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_FIN: begin
					rsp_q.list_length <= count_q[8:0];
					state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### tb/indexed_linked_list_engine_checker.sv
// ----------------------------------------------------------------------------
// indexed_linked_list_engine_checker
// Watches the request and result transactions of the list engine, keeps its
// own copy of the node store, free list, head and length, and compares each
// result with the oldest predicted one.
// ----------------------------------------------------------------------------
module indexed_linked_list_engine_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  ille_pkg::req_t req,
	input  logic           done,
	input  ille_pkg::rsp_t rsp,
	output int             error_count,
	output int             pending_count,
	output int             request_count,
	output int             result_count,
	output int             full_count,
	output int             hit_count
);
	import ille_pkg::*;

	localparam logic [8:0] NULL_LINK = 9'(CAPACITY);

	// Shadow copy of the list store.
	logic [31:0] shadow_value [CAPACITY];
	logic [8:0]  shadow_link  [CAPACITY];
	logic [8:0]  shadow_head;
	logic [8:0]  shadow_free;
	logic [8:0]  shadow_count;

	rsp_t expected_results [$];

	assign pending_count = expected_results.size();

	// Follows links from the head for the given number of steps.
	function automatic logic [8:0] node_at(input int steps);
		logic [8:0] cur;
		cur = shadow_head;
		for (int i = 0; i < steps && cur < NULL_LINK; i++)
			cur = shadow_link[cur];
		return cur;
	endfunction

	function automatic logic [8:0] link_of(input logic [8:0] n);
		return (n < NULL_LINK) ? shadow_link[n] : NULL_LINK;
	endfunction

	// Applies one request to the shadow store and returns its result.
	function automatic rsp_t apply_request(input req_t r);
		rsp_t res;
		logic [8:0] n;
		logic [8:0] prev;
		int pos;
		res = '0;
		pos = r.position;
		case (r.req_type)
			OP_GET, OP_SET: begin
				if (pos >= shadow_count) begin
					res.status = ST_RANGE;
				end else begin
					n = node_at(pos);
					if (n < NULL_LINK) begin
						res.data_out = shadow_value[n];
						if (r.req_type == OP_SET)
							shadow_value[n] = r.item_value;
					end
				end
			end
			OP_APPEND, OP_INSERT: begin
				if (r.req_type == OP_APPEND)
					pos = shadow_count;
				if (pos > shadow_count) begin
					res.status = ST_RANGE;
				end else if (shadow_free >= NULL_LINK) begin
					res.status = ST_FULL;
				end else begin
					n = shadow_free;
					shadow_free = shadow_link[n];
					shadow_value[n] = r.item_value;
					if (pos == 0) begin
						shadow_link[n] = shadow_head;
						shadow_head = n;
					end else begin
						prev = node_at(pos - 1);
						shadow_link[n] = link_of(prev);
						if (prev < NULL_LINK)
							shadow_link[prev] = n;
					end
					shadow_count++;
				end
			end
			OP_REMOVE: begin
				if (pos >= shadow_count) begin
					res.status = ST_RANGE;
				end else begin
					if (pos == 0) begin
						n = shadow_head;
						shadow_head = link_of(n);
					end else begin
						prev = node_at(pos - 1);
						n = link_of(prev);
						if (prev < NULL_LINK)
							shadow_link[prev] = link_of(n);
					end
					if (n < NULL_LINK) begin
						res.data_out = shadow_value[n];
						shadow_link[n] = shadow_free;
						shadow_free = n;
					end
					shadow_count--;
				end
			end
			OP_SEARCH: begin
				n = shadow_head;
				for (int i = 0; i < shadow_count && n < NULL_LINK; i++) begin
					if (shadow_value[n] == r.item_value) begin
						res.found = 1'b1;
						res.found_position = 8'(i);
						break;
					end
					n = shadow_link[n];
				end
			end
			default: ;
		endcase
		res.list_length = shadow_count;
		return res;
	endfunction

	// Predicts at each accepted request and compares each result transaction.
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		int errs;
		errs = 0;
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				shadow_value[i] = '0;
				shadow_link[i] = 9'(i + 1);
			end
			shadow_link[CAPACITY - 1] = NULL_LINK;
			shadow_head = NULL_LINK;
			shadow_free = '0;
			shadow_count = '0;
			expected_results.delete();
			error_count <= 0;
			request_count <= 0;
			result_count <= 0;
			full_count <= 0;
			hit_count <= 0;
		end else begin
			if (start && !busy) begin
				exp_rsp = apply_request(req);
				expected_results.push_back(exp_rsp);
				request_count <= request_count + 1;
			end
			if (done) begin
				result_count <= result_count + 1;
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected");
					errs++;
				end else begin
					exp_rsp = expected_results.pop_front();
					if (exp_rsp.status == ST_FULL)
						full_count <= full_count + 1;
					if (exp_rsp.found)
						hit_count <= hit_count + 1;
					if (rsp.status !== exp_rsp.status) begin
						$error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
						errs++;
					end
					if (rsp.data_out !== exp_rsp.data_out) begin
						$error("data_out: expected %0d, got %0d",
							exp_rsp.data_out, rsp.data_out);
						errs++;
					end
					if (rsp.found !== exp_rsp.found) begin
						$error("found: expected %0d, got %0d", exp_rsp.found, rsp.found);
						errs++;
					end
					if (rsp.found_position !== exp_rsp.found_position) begin
						$error("found_position: expected %0d, got %0d",
							exp_rsp.found_position, rsp.found_position);
						errs++;
					end
					if (rsp.list_length !== exp_rsp.list_length) begin
						$error("list_length: expected %0d, got %0d",
							exp_rsp.list_length, rsp.list_length);
						errs++;
					end
				end
				error_count <= error_count + errs;
			end
		end
	end
endmodule

### tb/tb_indexed_linked_list_engine.sv
// ----------------------------------------------------------------------------
// tb_indexed_linked_list_engine
// Drives directed and random list requests in bursts with random gaps,
// including runs that fill the store and drain it, and reports the verdict
// from the checker's error count.
// ----------------------------------------------------------------------------
module tb_indexed_linked_list_engine;
	import ille_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 270;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	int error_count;
	int pending_count;
	int request_count;
	int result_count;
	int full_count;
	int hit_count;
	int idle_cycles;
	int known_length = 0;
	bit growing;

	indexed_linked_list_engine uut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	indexed_linked_list_engine_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .error_count(error_count),
		.pending_count(pending_count), .request_count(request_count),
		.result_count(result_count), .full_count(full_count),
		.hit_count(hit_count)
	);

	always #5 clk = ~clk;

	// Tracks the list length from the latest result.
	always @(posedge clk) begin
		if (done)
			known_length <= rsp.list_length;
	end

	// Ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Presents one request and holds it until the engine takes it; start
	// stays high so the next request of a burst can follow directly.
	task automatic issue(input logic [2:0] op, input logic [8:0] pos,
		input logic [31:0] value);
		start <= 1'b1;
		req <= '{req_type: op, position: pos, item_value: value};
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Stops sending and waits until every expected result has come.
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		wait (pending_count == 0);
	endtask

	// Picks one random request biased toward valid positions.
	task automatic random_request();
		logic [2:0] op;
		logic [8:0] pos;
		logic [31:0] value;
		int pick;
		if (known_length >= CAPACITY)
			growing = 1'b0;
		else if (known_length == 0)
			growing = 1'b1;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			op = 3'($urandom_range(6, 7));
		else if (pick < 34)
			op = growing ? OP_APPEND : OP_REMOVE;
		else if (pick < 50)
			op = growing ? OP_INSERT : OP_GET;
		else
			op = 3'($urandom_range(OP_GET, OP_SEARCH));
		if ($urandom_range(0, 9) == 0)
			pos = 9'($urandom);
		else
			pos = 9'($urandom_range(0, known_length));
		if ($urandom_range(0, 3) == 0)
			value = $urandom;
		else
			value = 32'($urandom_range(0, 40));
		issue(op, pos, value);
	endtask

	initial begin
		int burst;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		growing = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: empty list errors, edge positions and values.
		issue(OP_GET, 9'd0, 32'd0);
		issue(OP_REMOVE, 9'd0, 32'd0);
		issue(OP_INSERT, 9'd1, 32'd5);
		issue(OP_SEARCH, 9'd0, 32'd5);
		issue(OP_APPEND, 9'h1FF, 32'h7FFF_FFFF);
		issue(OP_INSERT, 9'd0, 32'h8000_0000);
		issue(OP_INSERT, 9'd2, 32'hFFFF_FFFF);
		issue(OP_INSERT, 9'd1, 32'd0);
		issue(OP_GET, 9'd3, 32'd0);
		issue(OP_SET, 9'd0, 32'h5555_5555);
		issue(OP_SET, 9'd4, 32'd1);
		issue(OP_SEARCH, 9'd0, 32'hFFFF_FFFF);
		issue(OP_SEARCH, 9'd0, 32'h1234_5678);
		issue(3'd6, 9'h1FF, 32'hFFFF_FFFF);
		issue(3'd7, 9'd0, 32'd0);
		issue(OP_GET, 9'd256, 32'd0);
		issue(OP_INSERT, 9'd5, 32'd3);
		issue(OP_REMOVE, 9'd2, 32'd0);
		issue(OP_REMOVE, 9'd0, 32'd0);
		issue(OP_REMOVE, 9'd2, 32'd0);
		drain();

		// Fill the store to capacity, then refuse appends and inserts.
		for (int i = 0; i < CAPACITY; i++)
			issue(OP_APPEND, 9'd0, $urandom);
		issue(OP_APPEND, 9'd0, 32'd7);
		issue(OP_INSERT, 9'd100, 32'd7);
		issue(OP_INSERT, 9'd257, 32'd7);
		issue(OP_SEARCH, 9'd0, 32'h0BAD_F00D);
		drain();
		growing = 1'b0;

		// Random bursts with gaps; pauses in the middle of the run drain all pending results.
		for (int n = 0; n < RANDOM_ITEMS; n += burst) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst; k++)
				random_request();
			if (n > RANDOM_ITEMS / 2 && n < RANDOM_ITEMS / 2 + 13) begin
				drain();
			end else if ($urandom_range(0, 2) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end

		drain();
		repeat (600) @(posedge clk);
		$display("Covered %0d requests and %0d results, including %0d full-store refusals",
			request_count, result_count, full_count);
		$display("and %0d search hits across fill, drain and mixed random traffic.",
			hit_count);
		if (error_count == 0 && pending_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

### files.f
+incdir+rtl/core
rtl/core/ille_pkg.sv
rtl/core/ille_ram.sv
rtl/core/ille_front.sv
rtl/core/ille_back.sv
rtl/core/indexed_linked_list_engine.sv
tb/indexed_linked_list_engine_checker.sv
tb/tb_indexed_linked_list_engine.sv
